// ===== sv/spmb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the stereo peak meter: widths, fixed-point constants and the result type.
// No dependencies; used by every module of the meter.
package spmb_pkg;

  localparam int unsigned SampleBits = 24;
  localparam int unsigned NumChan = 4;
  localparam int unsigned SumBits = SampleBits + 1;
  localparam int unsigned TopBits = $clog2(SumBits);
  localparam int unsigned FracBits = 16;
  localparam int unsigned MantBits = 31;
  localparam int unsigned MulW = 32;
  localparam int unsigned ProdW = 64;
  localparam int unsigned MeterW = 16;
  localparam int unsigned DbW = 15;
  localparam int unsigned CoeffW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InTdataW = ((NumChan * SampleBits + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((NumChan * MeterW + 2 * DbW + 7) / 8) * 8;

  localparam logic [CfgIdxW-1:0] CFG_ATTACK = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_RELEASE = CfgIdxW'(1);
  localparam logic [CoeffW-1:0] AttackReset = CoeffW'(16384);
  localparam logic [CoeffW-1:0] ReleaseReset = CoeffW'(5243);

  localparam int DbK = 394566;
  localparam int DbShift = 24;
  localparam int DbFloor = -30720;
  localparam int DbMin = -15360;
  localparam int DbMax = 3072;
  localparam int MeterRecip = 4067204;
  localparam int MeterShift = 20;
  localparam int FolShift = 16;

  typedef struct packed {
    logic [1:0][DbW-1:0]          db;
    logic [NumChan-1:0][MeterW-1:0] meter;
  } res_t;

  function automatic logic [TopBits-1:0] msb_index(input logic [SumBits-1:0] x);
    logic [TopBits-1:0] top;
    top = '0;
    for (int i = 0; i < SumBits; i++) begin
      if (x[i]) begin
        top = TopBits'(i);
      end
    end
    return top;
  endfunction

endpackage

// ===== sv/spmb_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on spmb_pkg for the operand and product widths.
module spmb_mul (
  input  logic                                clk_i,
  input  logic signed [spmb_pkg::MulW-1:0]   a_i,
  input  logic signed [spmb_pkg::MulW-1:0]   b_i,
  output logic signed [spmb_pkg::ProdW-1:0]  p_o
);

  logic signed [spmb_pkg::ProdW-1:0] p_q;
  logic signed [spmb_pkg::ProdW-1:0] p_d;

  assign p_d = spmb_pkg::ProdW'(a_i) * spmb_pkg::ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== sv/spmb_peak.sv =====
`timescale 1ns / 1ps
// Running absolute peak per channel, with a snapshot taken and the peaks cleared on a block end.
// Depends on spmb_pkg for the sample width and channel count.
module spmb_peak (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                accept_i,
  input  logic                                                block_end_i,
  input  logic [spmb_pkg::NumChan-1:0][spmb_pkg::SampleBits-1:0] samples_i,
  output logic [spmb_pkg::NumChan-1:0][spmb_pkg::SampleBits-1:0] snap_o
);

  logic [spmb_pkg::NumChan-1:0][spmb_pkg::SampleBits-1:0] run_q, run_d;
  logic [spmb_pkg::NumChan-1:0][spmb_pkg::SampleBits-1:0] snap_q, snap_d;
  logic [spmb_pkg::NumChan-1:0][spmb_pkg::SampleBits-1:0] upd;
  logic [spmb_pkg::NumChan-1:0][spmb_pkg::SampleBits-1:0] mag;

  always_comb begin
    for (int i = 0; i < spmb_pkg::NumChan; i++) begin
      mag[i] = samples_i[i][spmb_pkg::SampleBits-1] ?
               (spmb_pkg::SampleBits'(0) - samples_i[i]) : samples_i[i];
      upd[i] = (mag[i] > run_q[i]) ? mag[i] : run_q[i];
    end
  end

  always_comb begin
    run_d  = run_q;
    snap_d = snap_q;
    if (accept_i) begin
      if (block_end_i) begin
        snap_d = upd;
        run_d  = '0;
      end else begin
        run_d = upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  assign snap_o = snap_q;

endmodule

// ===== sv/spmb_core.sv =====
`timescale 1ns / 1ps
// Sequencer that turns the peak snapshot into six smoothed levels with one shared multiplier.
// Depends on spmb_pkg and instantiates spmb_mul.
module spmb_core (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                start_i,
  input  logic [spmb_pkg::NumChan-1:0][spmb_pkg::SampleBits-1:0] peaks_i,
  input  logic [spmb_pkg::CoeffW-1:0]                         atk_i,
  input  logic [spmb_pkg::CoeffW-1:0]                         rel_i,
  input  logic                                                out_free_i,
  output logic                                                busy_o,
  output logic                                                res_valid_o,
  output spmb_pkg::res_t                                      res_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_LOAD = 10'b0000000010,
    S_SQR  = 10'b0000000100,
    S_DBM  = 10'b0000001000,
    S_DBR  = 10'b0000010000,
    S_POST = 10'b0000100000,
    S_MTRR = 10'b0001000000,
    S_FOL  = 10'b0010000000,
    S_FOLR = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  localparam int unsigned ValW = 18;
  localparam int unsigned DbProdW = 48;
  localparam int unsigned DbRawW = 20;
  localparam int unsigned FolProdW = 40;
  localparam int unsigned FolRawW = ValW + 1;
  localparam int unsigned MtrQW = 20;
  localparam int unsigned MantQ = spmb_pkg::MantBits - 1;
  localparam logic [2:0] LastIdx = 3'd5;
  localparam logic [2:0] PairIdx = 3'd4;
  localparam logic signed [DbRawW-1:0] FloorRaw = DbRawW'(spmb_pkg::DbFloor);
  localparam logic signed [ValW-1:0] FloorV = ValW'(spmb_pkg::DbFloor);
  localparam logic signed [ValW-1:0] DbMinV = ValW'(spmb_pkg::DbMin);
  localparam logic signed [ValW-1:0] DbMaxV = ValW'(spmb_pkg::DbMax);
  localparam logic [MtrQW-1:0] MeterMax = MtrQW'((1 << spmb_pkg::MeterW) - 1);

  state_e state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic [3:0] cnt_q, cnt_d;
  logic [spmb_pkg::TopBits-1:0] top_q, top_d;
  logic [spmb_pkg::FracBits-1:0] frac_q, frac_d;
  logic signed [ValW-1:0] db_q, db_d;
  logic signed [ValW-1:0] tgt_q, tgt_d;
  logic [spmb_pkg::NumChan-1:0][spmb_pkg::MeterW-1:0] meter_q, meter_d;
  logic [1:0][spmb_pkg::DbW-1:0] lvl_q, lvl_d;

  logic signed [spmb_pkg::MulW-1:0] mul_a, mul_b;
  logic signed [spmb_pkg::ProdW-1:0] prod;

  logic is_pair;
  logic [spmb_pkg::SumBits-1:0] x;
  logic [spmb_pkg::TopBits-1:0] top;
  logic [spmb_pkg::SumBits+MantQ-1:0] wide;
  logic [spmb_pkg::MantBits-1:0] mant, mnext;
  logic sq_carry;
  logic [spmb_pkg::TopBits-1:0] fbits;
  logic signed [spmb_pkg::MulW-1:0] log_rel;

  logic [DbProdW-1:0] db_mag, db_sum;
  logic [DbRawW-1:0] db_abs;
  logic signed [DbRawW-1:0] db_raw;

  logic [ValW-1:0] mtr_n;
  logic [MtrQW-1:0] mtr_q;

  logic signed [ValW-1:0] held, diff;
  logic [spmb_pkg::CoeffW-1:0] coeff;
  logic [FolProdW-1:0] fol_mag, fol_sum;
  logic [FolRawW-1:0] fol_abs;
  logic signed [FolRawW-1:0] fol_new;

  spmb_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign is_pair = (idx_q >= PairIdx);

  always_comb begin
    case (idx_q)
      3'd0, 3'd1, 3'd2, 3'd3: x = {1'b0, peaks_i[idx_q[1:0]]};
      PairIdx: x = {1'b0, peaks_i[0]} + {1'b0, peaks_i[1]};
      default: x = {1'b0, peaks_i[2]} + {1'b0, peaks_i[3]};
    endcase
  end

  assign top = spmb_pkg::msb_index(x);
  assign wide = {x, {MantQ{1'b0}}} >> top;
  assign mant = wide[spmb_pkg::MantBits-1:0];

  assign sq_carry = prod[2*spmb_pkg::MantBits-1];
  assign mnext = sq_carry ? prod[2*spmb_pkg::MantBits-1 -: spmb_pkg::MantBits]
                          : prod[2*spmb_pkg::MantBits-2 -: spmb_pkg::MantBits];

  assign fbits = is_pair ? spmb_pkg::TopBits'(spmb_pkg::SampleBits)
                         : spmb_pkg::TopBits'(spmb_pkg::SampleBits - 1);
  assign log_rel = $signed(spmb_pkg::MulW'({top_q, frac_q})) -
                   $signed(spmb_pkg::MulW'(fbits) << spmb_pkg::FracBits);

  assign db_mag = prod[DbProdW-1] ? (~prod[DbProdW-1:0] + 1'b1) : prod[DbProdW-1:0];
  assign db_sum = db_mag + (DbProdW'(1) << (spmb_pkg::DbShift - 1));
  assign db_abs = {1'b0, db_sum[spmb_pkg::DbShift +: DbRawW-1]};
  assign db_raw = prod[DbProdW-1] ? -$signed(db_abs) : $signed(db_abs);

  assign mtr_n = (db_q > DbMinV) ? ValW'(db_q - DbMinV) : '0;
  assign mtr_q = prod[spmb_pkg::MeterShift +: MtrQW];

  assign held = is_pair ? ValW'($signed(lvl_q[idx_q[0]]))
                        : $signed({2'b00, meter_q[idx_q[1:0]]});
  assign diff = tgt_q - held;
  assign coeff = (tgt_q > held) ? atk_i : rel_i;
  assign fol_mag = prod[FolProdW-1] ? (~prod[FolProdW-1:0] + 1'b1) : prod[FolProdW-1:0];
  assign fol_sum = fol_mag + (FolProdW'(1) << (spmb_pkg::FolShift - 1));
  assign fol_abs = {1'b0, fol_sum[spmb_pkg::FolShift +: FolRawW-1]};
  assign fol_new = FolRawW'(held) +
                   (prod[FolProdW-1] ? -$signed(fol_abs) : $signed(fol_abs));

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    top_d = top_q;
    frac_d = frac_q;
    db_d = db_q;
    tgt_d = tgt_q;
    meter_d = meter_q;
    lvl_d = lvl_q;
    res_valid_o = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          idx_d = '0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        mul_a = spmb_pkg::MulW'(mant);
        mul_b = spmb_pkg::MulW'(mant);
        if (x == '0) begin
          db_d = FloorV;
          state_d = S_POST;
        end else begin
          top_d = top;
          frac_d = '0;
          cnt_d = 4'd15;
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        mul_a = spmb_pkg::MulW'(mnext);
        mul_b = spmb_pkg::MulW'(mnext);
        frac_d[cnt_q] = sq_carry;
        if (cnt_q == '0) begin
          state_d = S_DBM;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      S_DBM: begin
        mul_a = log_rel;
        mul_b = spmb_pkg::MulW'(spmb_pkg::DbK);
        state_d = S_DBR;
      end
      S_DBR: begin
        db_d = (db_raw < FloorRaw) ? FloorV : ValW'(db_raw);
        state_d = S_POST;
      end
      S_POST: begin
        if (is_pair) begin
          if (db_q < DbMinV) begin
            tgt_d = DbMinV;
          end else if (db_q > DbMaxV) begin
            tgt_d = DbMaxV;
          end else begin
            tgt_d = db_q;
          end
          state_d = S_FOL;
        end else begin
          mul_a = spmb_pkg::MulW'(mtr_n);
          mul_b = spmb_pkg::MulW'(spmb_pkg::MeterRecip);
          state_d = S_MTRR;
        end
      end
      S_MTRR: begin
        tgt_d = $signed({2'b00, (mtr_q > MeterMax) ? MeterMax[spmb_pkg::MeterW-1:0]
                                                   : mtr_q[spmb_pkg::MeterW-1:0]});
        state_d = S_FOL;
      end
      S_FOL: begin
        mul_a = spmb_pkg::MulW'(diff);
        mul_b = spmb_pkg::MulW'(coeff);
        state_d = S_FOLR;
      end
      S_FOLR: begin
        if (is_pair) begin
          lvl_d[idx_q[0]] = fol_new[spmb_pkg::DbW-1:0];
        end else begin
          meter_d[idx_q[1:0]] = fol_new[spmb_pkg::MeterW-1:0];
        end
        if (idx_q == LastIdx) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 3'd1;
          state_d = S_LOAD;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      meter_q <= '0;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      meter_q <= meter_d;
      lvl_q   <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    top_q  <= top_d;
    frac_q <= frac_d;
    db_q   <= db_d;
    tgt_q  <= tgt_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_o.meter = meter_q;
  assign res_o.db = lvl_q;

endmodule

// ===== sv/stereo_peak_meter_ballistics.sv =====
`timescale 1ns / 1ps
// Stereo peak meter with attack and release smoothing, top level.
// Depends on spmb_pkg and instantiates spmb_peak and spmb_core.
//
// Each input item is one stereo frame: the input pair and the output pair of a
// processor, 24-bit two's complement, with tlast marking the last frame of a block.
// Frames without tlast only update the running peaks, and the block stays ready
// after each of them. A frame with tlast snapshots and clears the peaks, and the
// sequencer then forms six levels with a single shared multiplier: a base-2 log
// by sixteen squarings, the dB scaling, the meter mapping and the smoothing step.
// A silent peak or pair skips the log and the dB scaling. tready stays low from
// the block end until its result item is offered. The result sits in an output
// register. While it waits, further frames without tlast are still accepted; a
// new block end finishes its work and then holds until the receiver has taken
// the earlier result. Reset clears the peaks and the smoothed levels and loads
// the default attack and release coefficients; the user must write them over the
// configuration port only while the block is idle; the block does not enforce this.
module stereo_peak_meter_ballistics (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // in_left, in_right, out_left, out_right from the lowest bit up.
  input  logic [spmb_pkg::InTdataW-1:0]         s_axis_tdata,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // in_meter_left, in_meter_right, out_meter_left, out_meter_right, in_level_db,
  // out_level_db from the lowest bit up, then zero padding.
  output logic [spmb_pkg::OutTdataW-1:0]        m_axis_tdata,
  input  logic                                  cfg_we_i,
  input  logic [spmb_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [spmb_pkg::CoeffW-1:0]           cfg_data_i
);

  logic in_accept;
  logic busy;
  logic out_free;
  logic res_valid;
  spmb_pkg::res_t res;
  logic [spmb_pkg::NumChan-1:0][spmb_pkg::SampleBits-1:0] samples;
  logic [spmb_pkg::NumChan-1:0][spmb_pkg::SampleBits-1:0] snap;
  logic [spmb_pkg::CoeffW-1:0] atk_q, atk_d, rel_q, rel_d;
  logic out_valid_q, out_valid_d;
  spmb_pkg::res_t out_data_q, out_data_d;

  assign samples = s_axis_tdata[spmb_pkg::NumChan*spmb_pkg::SampleBits-1:0];
  assign s_axis_tready = !busy;
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  spmb_peak u_peak (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .block_end_i (s_axis_tlast),
    .samples_i   (samples),
    .snap_o      (snap)
  );

  spmb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept && s_axis_tlast),
    .peaks_i     (snap),
    .atk_i       (atk_q),
    .rel_i       (rel_q),
    .out_free_i  (out_free),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    atk_d = atk_q;
    rel_d = rel_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        spmb_pkg::CFG_ATTACK: atk_d = cfg_data_i;
        spmb_pkg::CFG_RELEASE: rel_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d = out_data_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_data_d = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atk_q       <= spmb_pkg::AttackReset;
      rel_q       <= spmb_pkg::ReleaseReset;
      out_valid_q <= 1'b0;
    end else begin
      atk_q       <= atk_d;
      rel_q       <= rel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = spmb_pkg::OutTdataW'(out_data_q);

endmodule
